// File: design/igd_pkg.sv
`timescale 1ns / 1ps

package igd_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int OPC_W     = 3;
  localparam int DIR_W     = 2;
  localparam int SPEED_W   = 24;
  localparam int SUS_W     = 16;
  localparam int DELTA_W   = 8;
  localparam int MOVE_W    = 8;
  localparam int ERR_W     = 40;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int P_W       = 17;
  localparam int STEP_W    = 4;
  localparam int BIT_IDX_W = 3;

  localparam logic [CFG_W-1:0] DECAY_RST = 16'd64880;
  localparam logic [CFG_W-1:0] EPS_RST   = 16'd655;

  // Operation codes of an input transaction
  typedef enum logic [OPC_W-1:0] {
    OPC_TICK    = 3'd0,
    OPC_SET_DIR = 3'd1,
    OPC_LOAD_SS = 3'd2,
    OPC_LOAD_S  = 3'd3,
    OPC_STOP    = 3'd4
  } opc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY = 1'b0,
    CFG_EPS   = 1'b1
  } cfg_idx_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    DP_NOP   = 4'd0,
    DP_MUL   = 4'd1,
    DP_ACC   = 4'd2,
    DP_ROUND = 4'd3,
    DP_SUBTR = 4'd4,
    DP_SUS   = 4'd5,
    DP_PINIT = 4'd6,
    DP_SQ    = 4'd7,
    DP_MULD  = 4'd8,
    DP_NEXT  = 4'd9,
    DP_MAG   = 4'd10,
    DP_SNAP  = 4'd11
  } dp_op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    CND_NONE     = 2'd0,
    CND_SUS_ZERO = 2'd1,
    CND_BIT_CLR  = 2'd2,
    CND_IDX_NZ   = 2'd3
  } cond_t;

  typedef struct packed {
    dp_op_t              op;
    cond_t               cond;
    logic [STEP_W-1:0]   target;
    logic                last;
  } ctrl_word_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic sus_zero;
    logic bit_set;
    logic idx_nz;
    logic stopped;
  } dp_status_t;

  localparam logic [STEP_W-1:0] UA_DECAY = 4'd5;
  localparam logic [STEP_W-1:0] UA_SQ    = 4'd6;
  localparam logic [STEP_W-1:0] UA_NEXT  = 4'd8;
  localparam logic [STEP_W-1:0] UA_LAST  = 4'd10;

  // Glide tick program
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{op: DP_NOP, cond: CND_NONE, target: '0, last: 1'b1};
    unique case (step)
      4'd0:  cw = '{op: DP_MUL,   cond: CND_NONE,     target: '0,       last: 1'b0};
      4'd1:  cw = '{op: DP_ACC,   cond: CND_NONE,     target: '0,       last: 1'b0};
      4'd2:  cw = '{op: DP_ROUND, cond: CND_NONE,     target: '0,       last: 1'b0};
      4'd3:  cw = '{op: DP_SUBTR, cond: CND_SUS_ZERO, target: UA_DECAY, last: 1'b0};
      4'd4:  cw = '{op: DP_SUS,   cond: CND_NONE,     target: '0,       last: 1'b1};
      4'd5:  cw = '{op: DP_PINIT, cond: CND_NONE,     target: '0,       last: 1'b0};
      4'd6:  cw = '{op: DP_SQ,    cond: CND_BIT_CLR,  target: UA_NEXT,  last: 1'b0};
      4'd7:  cw = '{op: DP_MULD,  cond: CND_NONE,     target: '0,       last: 1'b0};
      4'd8:  cw = '{op: DP_NEXT,  cond: CND_IDX_NZ,   target: UA_SQ,    last: 1'b0};
      4'd9:  cw = '{op: DP_MAG,   cond: CND_NONE,     target: '0,       last: 1'b0};
      4'd10: cw = '{op: DP_SNAP,  cond: CND_NONE,     target: '0,       last: 1'b1};
      default: cw = '{op: DP_NOP, cond: CND_NONE,     target: '0,       last: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

// File: design/igd_if.sv
`timescale 1ns / 1ps

interface igd_in_if;
  import igd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OPC_W-1:0]          operation;
  logic signed [DIR_W-1:0]   direction;
  logic signed [SPEED_W-1:0] speed_in;
  logic [SUS_W-1:0]          sustain_in;
  logic [DELTA_W-1:0]        delta_ms;

  modport source (output valid, operation, direction, speed_in, sustain_in, delta_ms,
                  input ready);
  modport sink   (input valid, operation, direction, speed_in, sustain_in, delta_ms,
                  output ready);
endinterface

interface igd_out_if;
  import igd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] movement;
  logic                     just_stopped;

  modport source (output valid, movement, just_stopped, input ready);
  modport sink   (input valid, movement, just_stopped, output ready);
endinterface

// File: design/inertial_glide_decay.sv
`timescale 1ns / 1ps

// Inertial glide for pointer or scroll motion.
// in_if carries one command per transaction: glide tick, set direction, load speed and
// sustain, load speed, or stop. Only a glide tick returns a transaction on out_if
// (movement and just_stopped); the other commands update state in the accepting cycle.
// cfg_we/cfg_index/cfg_wdata write the decay factor (index 0) and the snap threshold
// (index 1); write them only while no tick is in flight.
// A tick is run by a small microcode program on one shared datapath. While sustain time
// remains the tick ends by spending sustain; otherwise it raises the decay factor to the
// power delta_ms in eight square-and-multiply rounds, with a multiply step only for each
// set bit of delta_ms, and scales the speed. in_if.ready is low while a tick runs.
// The result sits in an output register, so the next command is accepted while it waits.
// If a second tick finishes while the first result is still not taken, the program holds
// at its final step until out_if.ready frees the register.
// Reset clears speed, sustain, error and direction and reloads both configuration
// registers with their defaults; no result is pending afterwards.
module inertial_glide_decay #(
  parameter int FRAC_BITS = igd_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  igd_in_if.sink                          in_if,
  igd_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [igd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [igd_pkg::CFG_W-1:0]       cfg_wdata
);
  import igd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CFG_W-1:0]    decay_r, eps_r;
  logic                out_valid_r, out_valid_nxt;
  logic signed [MOVE_W-1:0] movement_r;
  logic                stopped_r;

  ctrl_word_t  cw;
  dp_ctrl_t    dp_ctrl;
  dp_status_t  dp_stat;
  logic signed [MOVE_W-1:0] dp_move;
  logic        in_take, out_take, slot_busy, exec, jump, finish;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign out_take    = out_if.valid && out_if.ready;
  assign slot_busy   = out_valid_r && !out_if.ready;

  assign cw = ucode_rom(step_r);

  // hold the final step while the previous result still waits
  assign exec   = (state_r == ST_RUN) && !(cw.last && slot_busy);
  assign finish = exec && cw.last;

  always_comb begin
    unique case (cw.cond)
      CND_NONE:     jump = 1'b0;
      CND_SUS_ZERO: jump = dp_stat.sus_zero;
      CND_BIT_CLR:  jump = !dp_stat.bit_set;
      CND_IDX_NZ:   jump = dp_stat.idx_nz;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_take;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && in_if.operation == OPC_TICK) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (exec) begin
          step_nxt = jump ? cw.target : step_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign dp_ctrl.take = in_take;
  assign dp_ctrl.op   = exec ? cw.op : DP_NOP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      decay_r     <= DECAY_RST;
      eps_r       <= EPS_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DECAY: decay_r <= cfg_wdata;
          CFG_EPS:   eps_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      movement_r <= dp_move;
      stopped_r  <= dp_stat.stopped;
    end
  end

  igd_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (dp_ctrl),
    .operation  (in_if.operation),
    .direction  (in_if.direction),
    .speed_in   (in_if.speed_in),
    .sustain_in (in_if.sustain_in),
    .delta_ms   (in_if.delta_ms),
    .decay      (decay_r),
    .epsilon    (eps_r),
    .status     (dp_stat),
    .movement   (dp_move)
  );

  assign out_if.valid        = out_valid_r;
  assign out_if.movement     = movement_r;
  assign out_if.just_stopped = stopped_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= UA_LAST))
    else $error("microcode step beyond program");

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_if.operation == OPC_TICK) |=> (state_r == ST_RUN && step_r == '0))
    else $error("accepted tick did not start the program");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN && cw.last))
    else $error("result raised outside the final step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> $stable(movement_r) && $stable(stopped_r))
    else $error("pending result overwritten");

endmodule

// File: design/igd_datapath.sv
`timescale 1ns / 1ps

module igd_datapath #(
  parameter int FRAC_BITS = igd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  igd_pkg::dp_ctrl_t                  ctrl,
  input  logic [igd_pkg::OPC_W-1:0]          operation,
  input  logic signed [igd_pkg::DIR_W-1:0]   direction,
  input  logic signed [igd_pkg::SPEED_W-1:0] speed_in,
  input  logic [igd_pkg::SUS_W-1:0]          sustain_in,
  input  logic [igd_pkg::DELTA_W-1:0]        delta_ms,
  input  logic [igd_pkg::CFG_W-1:0]          decay,
  input  logic [igd_pkg::CFG_W-1:0]          epsilon,
  output igd_pkg::dp_status_t                status,
  output logic signed [igd_pkg::MOVE_W-1:0]  movement
);
  import igd_pkg::*;

  localparam int PROD_W = SPEED_W + DELTA_W + 1;
  localparam int MV_W   = DIR_W + MOVE_W;
  localparam logic signed [ERR_W:0]   RND_ADD = (ERR_W+1)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic [P_W-1:0]          P_ONE   = 17'h10000;

  // architectural state
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic [SUS_W-1:0]          sus_r, sus_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [DIR_W-1:0]   dir_r, dir_nxt;
  // working registers
  logic [DELTA_W-1:0]        delta_r, delta_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [MOVE_W-1:0]  dist_r, dist_nxt;
  logic signed [MOVE_W-1:0]  mv_r, mv_nxt;
  logic [P_W-1:0]            p_r, p_nxt;
  logic [BIT_IDX_W-1:0]      idx_r, idx_nxt;
  logic [SPEED_W-1:0]        mag_r, mag_nxt;
  logic                      moving_r, moving_nxt;

  logic signed [ERR_W:0]     err_ext, acc_sum, rnd_sum, quot;
  logic signed [ERR_W-1:0]   dist_ext;
  logic signed [MV_W-1:0]    mv_full;
  logic [2*P_W-1:0]          sq_full;
  logic [P_W+CFG_W-1:0]      pd_full;
  logic [SPEED_W-1:0]        spd_abs, snap_mag;
  logic [SPEED_W+P_W-1:0]    mag_full;
  logic [SUS_W-1:0]          sus_spend;

  always_comb begin
    speed_nxt  = speed_r;
    sus_nxt    = sus_r;
    err_nxt    = err_r;
    dir_nxt    = dir_r;
    delta_nxt  = delta_r;
    prod_nxt   = prod_r;
    dist_nxt   = dist_r;
    mv_nxt     = mv_r;
    p_nxt      = p_r;
    idx_nxt    = idx_r;
    mag_nxt    = mag_r;
    moving_nxt = moving_r;

    err_ext  = {err_r[ERR_W-1], err_r};
    acc_sum  = err_ext + {{(ERR_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    rnd_sum  = (!err_r[ERR_W-1] && err_r != '0) ? err_ext + RND_ADD : err_ext;
    quot     = rnd_sum >>> FRAC_BITS;
    dist_ext = {{(ERR_W-MOVE_W){dist_r[MOVE_W-1]}}, dist_r};
    mv_full  = dir_r * dist_r;
    sq_full  = p_r * p_r + (2*P_W)'(16'h8000);
    pd_full  = p_r * decay + (P_W+CFG_W)'(16'h8000);
    spd_abs  = speed_r[SPEED_W-1] ? (~speed_r + 1'b1) : speed_r;
    mag_full = spd_abs * p_r + (SPEED_W+P_W)'(16'h8000);
    snap_mag = (mag_r < {{(SPEED_W-CFG_W){1'b0}}, epsilon}) ? '0 : mag_r;
    sus_spend = (sus_r < {{(SUS_W-DELTA_W){1'b0}}, delta_r}) ? sus_r
                                                             : {{(SUS_W-DELTA_W){1'b0}}, delta_r};

    if (ctrl.take) begin
      unique case (operation)
        OPC_TICK:    delta_nxt = delta_ms;
        OPC_SET_DIR: begin
          if (direction != dir_r) begin
            speed_nxt = '0;
            sus_nxt   = '0;
            err_nxt   = '0;
          end
          dir_nxt = direction;
        end
        OPC_LOAD_SS: begin
          speed_nxt = speed_in;
          sus_nxt   = sustain_in;
        end
        OPC_LOAD_S:  speed_nxt = speed_in;
        OPC_STOP: begin
          speed_nxt = '0;
          sus_nxt   = '0;
          err_nxt   = '0;
        end
        default: ;
      endcase
    end else begin
      unique case (ctrl.op)
        DP_MUL: begin
          prod_nxt   = speed_r * $signed({1'b0, delta_r});
          moving_nxt = (speed_r != '0);
        end
        DP_ACC: begin
          // saturate the error on overflow
          if (acc_sum[ERR_W] != acc_sum[ERR_W-1]) begin
            err_nxt = acc_sum[ERR_W] ? ERR_MIN : ERR_MAX;
          end else begin
            err_nxt = acc_sum[ERR_W-1:0];
          end
        end
        DP_ROUND: begin
          if (quot > (ERR_W+1)'(127)) begin
            dist_nxt = 8'sd127;
          end else if (quot < -(ERR_W+1)'(128)) begin
            dist_nxt = -8'sd128;
          end else begin
            dist_nxt = quot[MOVE_W-1:0];
          end
        end
        DP_SUBTR: begin
          err_nxt = err_r - (dist_ext <<< FRAC_BITS);
          if (mv_full > MV_W'(127)) begin
            mv_nxt = 8'sd127;
          end else if (mv_full < -MV_W'(128)) begin
            mv_nxt = -8'sd128;
          end else begin
            mv_nxt = mv_full[MOVE_W-1:0];
          end
        end
        DP_SUS:   sus_nxt = sus_r - sus_spend;
        DP_PINIT: begin
          p_nxt   = P_ONE;
          idx_nxt = '1;
        end
        DP_SQ:    p_nxt = sq_full[P_W+15:16];
        DP_MULD:  p_nxt = pd_full[P_W+15:16];
        DP_NEXT:  idx_nxt = idx_r - 1'b1;
        DP_MAG:   mag_nxt = mag_full[SPEED_W+15:16];
        DP_SNAP:  speed_nxt = speed_r[SPEED_W-1] ? (~snap_mag + 1'b1) : snap_mag;
        DP_NOP:   ;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      sus_r   <= '0;
      err_r   <= '0;
      dir_r   <= '0;
    end else begin
      speed_r <= speed_nxt;
      sus_r   <= sus_nxt;
      err_r   <= err_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r  <= delta_nxt;
    prod_r   <= prod_nxt;
    dist_r   <= dist_nxt;
    mv_r     <= mv_nxt;
    p_r      <= p_nxt;
    idx_r    <= idx_nxt;
    mag_r    <= mag_nxt;
    moving_r <= moving_nxt;
  end

  assign status.sus_zero = (sus_r == '0);
  assign status.bit_set  = delta_r[idx_r];
  assign status.idx_nz   = (idx_r != '0);
  assign status.stopped  = moving_r && (speed_nxt == '0);
  assign movement        = mv_r;

endmodule
